// ===== src/adaptive_ema_sensor_smoother_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive EMA sensor smoother
// Each macro builds one concurrent check, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_EMA_SENSOR_SMOOTHER_DEFINES_SVH
`define ADAPTIVE_EMA_SENSOR_SMOOTHER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define AES_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aes check failed");
// next-cycle implication
`define AES_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aes check failed");
`else
`define AES_ASSERT_IMP(lbl, ante, cons)
`define AES_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants for the adaptive EMA sensor smoother.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aes_pkg;

   localparam int SAMPLE_BITS_DEF   = 10;
   localparam int FRACTION_BITS_DEF = 16;

   // multiplier register is Q0.16 regardless of the value format
   localparam int MULT_BITS = 16;
   localparam int MULT_FRAC = 16;

   localparam int MULT_RESET = 1311;
   localparam int MAXV_RESET = 999;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic REG_MULT = 1'b0;
   localparam logic REG_MAXV = 1'b1;

endpackage

// ===== src/aes_dist_mult.sv =====
// ----------------------------------------------------------------------------
// aes_dist_mult
// Shift-add multiplier, one bit of the distance per cycle: diff * multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_dist_mult import aes_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [SAMPLE_BITS-1:0]           diff,
   input  logic [MULT_BITS-1:0]             mult,
   output logic                             done,
   output logic [SAMPLE_BITS+MULT_BITS-1:0] product
);

   localparam int PW = SAMPLE_BITS + MULT_BITS;
   localparam int CW = $clog2(SAMPLE_BITS + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [SAMPLE_BITS-1:0] diff_sh_ff, diff_sh_in;
   logic [PW-1:0]          mcand_ff, mcand_in;
   logic [PW-1:0]          acc_ff, acc_in;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      diff_sh_in = diff_sh_ff;
      mcand_in   = mcand_ff;
      acc_in     = acc_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CW'(SAMPLE_BITS);
         diff_sh_in = diff;
         mcand_in   = PW'(mult);
         acc_in     = '0;
      end else if (busy_ff) begin
         if (diff_sh_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         diff_sh_in = diff_sh_ff >> 1;
         mcand_in   = mcand_ff << 1;
         cnt_in     = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_sh_ff <= diff_sh_in;
      mcand_ff   <= mcand_in;
      acc_ff     <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== src/aes_gain_div.sv =====
// ----------------------------------------------------------------------------
// aes_gain_div
// Restoring divider, one quotient bit per cycle: gain = 2d*2^F / (d + 2^16),
// saturated to one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_gain_div import aes_pkg::*; #(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [SAMPLE_BITS+MULT_BITS-1:0] scaled,
   output logic                             done,
   output logic [FRACTION_BITS:0]           gain
);

   localparam int DW = SAMPLE_BITS + MULT_BITS + 1;
   localparam int CW = $clog2(FRACTION_BITS + 2);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [DW-1:0]          den_ff, den_in;
   logic [DW-1:0]          rem_ff, rem_in;
   logic [FRACTION_BITS:0] quot_ff, quot_in;
   logic [DW:0]            trial;
   logic [DW:0]            trial_sub;
   logic                   fits;

   assign trial     = {rem_ff, 1'b0};
   assign trial_sub = trial - {1'b0, den_ff};
   assign fits      = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(FRACTION_BITS + 1);
         den_in  = DW'(scaled) + (DW'(1) << MULT_FRAC);
         // first doubling yields 2d, which sets the integer bit
         rem_in  = DW'(scaled);
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? trial_sub[DW-1:0] : trial[DW-1:0];
         quot_in = {quot_ff[FRACTION_BITS-1:0], fits};
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign gain = quot_ff[FRACTION_BITS] ? {1'b1, {FRACTION_BITS{1'b0}}} : quot_ff;

endmodule

// ===== src/aes_step_mult.sv =====
// ----------------------------------------------------------------------------
// aes_step_mult
// Right-shifting serial multiplier: step = floor(mag * gain / 2^F),
// one gain bit per cycle, LSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_step_mult import aes_pkg::*; #(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [SAMPLE_BITS+FRACTION_BITS-1:0] mag,
   input  logic [FRACTION_BITS:0]               gain,
   output logic                                 done,
   output logic [SAMPLE_BITS+FRACTION_BITS-1:0] step
);

   localparam int VW = SAMPLE_BITS + FRACTION_BITS;
   localparam int AW = VW + 1;
   localparam int CW = $clog2(FRACTION_BITS + 2);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [VW-1:0]          mag_ff, mag_in;
   logic [FRACTION_BITS:0] gsh_ff, gsh_in;
   logic [AW-1:0]          acc_ff, acc_in;
   logic [AW-1:0]          sum;

   assign sum = acc_ff + (gsh_ff[0] ? AW'(mag_ff) : AW'(0));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      gsh_in  = gsh_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(FRACTION_BITS + 1);
         mag_in  = mag;
         gsh_in  = gain;
         acc_in  = '0;
      end else if (busy_ff) begin
         gsh_in = gsh_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         // integer gain bit has weight 2^F: add without the shift
         if (cnt_ff == CW'(1)) begin
            acc_in  = sum;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            acc_in = sum >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      gsh_ff <= gsh_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign step = acc_ff[VW-1:0];

endmodule

// ===== src/adaptive_ema_sensor_smoother.sv =====
// ----------------------------------------------------------------------------
// adaptive_ema_sensor_smoother: adaptive EMA over converter samples
// A request is accepted only in ST_IDLE, then runs the bit-serial multiply,
// divide and multiply one after another; the next request is taken only once
// the result is in the output register; ST_DONE holds while it is still full.
// Reset (sync, high): smoothed value 0, multiplier 1311, max_value 999.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "adaptive_ema_sensor_smoother_defines.svh"

module adaptive_ema_sensor_smoother import aes_pkg::*; #(
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [SAMPLE_BITS-1:0]               req_sample,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [SAMPLE_BITS+FRACTION_BITS-1:0] rsp_smoothed_out,

   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]             csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]             csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]             csr_prdata,
   output logic                                 csr_pready
);

   localparam int VW = SAMPLE_BITS + FRACTION_BITS;
   localparam int PW = SAMPLE_BITS + MULT_BITS;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_STEP = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic                   mul_start_ff, mul_start_in;
   logic                   div_start_ff, div_start_in;
   logic                   step_start_ff, step_start_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]          rsp_out_ff, rsp_out_in;
   logic [VW-1:0]          smoothed_ff, smoothed_in;
   logic [VW-1:0]          mag_ff, mag_in;
   logic                   up_ff, up_in;
   logic [MULT_BITS-1:0]   mult_ff, mult_in;
   logic [SAMPLE_BITS-1:0] maxv_ff, maxv_in;

   logic                   req_fire;
   logic                   csr_write;
   logic [VW-1:0]          target;
   logic [VW-1:0]          next_val;
   logic [VW-1:0]          limit;
   logic [VW-1:0]          clamped;
   logic                   mul_done;
   logic                   div_done;
   logic                   step_done;
   logic [PW-1:0]          scaled;
   logic [FRACTION_BITS:0] gain;
   logic [VW-1:0]          step;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   assign target   = {req_sample, {FRACTION_BITS{1'b0}}};
   assign limit    = {maxv_ff, {FRACTION_BITS{1'b0}}};
   // step never exceeds the distance, so neither side wraps
   assign next_val = up_ff ? (smoothed_ff + step) : (smoothed_ff - step);
   assign clamped  = (next_val > limit) ? limit : next_val;

   always_comb begin
      csr_prdata = {{(CSR_DATA_BITS-MULT_BITS){1'b0}}, mult_ff};
      if (csr_paddr[2] == REG_MAXV) begin
         csr_prdata = {{(CSR_DATA_BITS-SAMPLE_BITS){1'b0}}, maxv_ff};
      end
   end

   always_comb begin
      mult_in = mult_ff;
      maxv_in = maxv_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_MULT: mult_in = csr_pwdata[MULT_BITS-1:0];
            REG_MAXV: maxv_in = csr_pwdata[SAMPLE_BITS-1:0];
            default:  mult_in = mult_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      mul_start_in  = 1'b0;
      div_start_in  = 1'b0;
      step_start_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_out_in    = rsp_out_ff;
      smoothed_in   = smoothed_ff;
      mag_in        = mag_ff;
      up_in         = up_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               up_in        = target >= smoothed_ff;
               mag_in       = (target >= smoothed_ff) ? (target - smoothed_ff)
                                                      : (smoothed_ff - target);
               mul_start_in = 1'b1;
               state_in     = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               div_start_in = 1'b1;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               step_start_in = 1'b1;
               state_in      = ST_STEP;
            end
         end
         ST_STEP: begin
            if (step_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               smoothed_in  = clamped;
               rsp_out_in   = clamped;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mul_start_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
         step_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         smoothed_ff   <= '0;
         mult_ff       <= MULT_BITS'(MULT_RESET);
         maxv_ff       <= SAMPLE_BITS'(MAXV_RESET);
      end else begin
         state_ff      <= state_in;
         mul_start_ff  <= mul_start_in;
         div_start_ff  <= div_start_in;
         step_start_ff <= step_start_in;
         rsp_valid_ff  <= rsp_valid_in;
         smoothed_ff   <= smoothed_in;
         mult_ff       <= mult_in;
         maxv_ff       <= maxv_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_out_ff <= rsp_out_in;
      mag_ff     <= mag_in;
      up_ff      <= up_in;
   end

   aes_dist_mult #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dist_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .diff    (mag_ff[VW-1:FRACTION_BITS]),
      .mult    (mult_ff),
      .done    (mul_done),
      .product (scaled)
   );

   aes_gain_div #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_gain_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start_ff),
      .scaled (scaled),
      .done   (div_done),
      .gain   (gain)
   );

   aes_step_mult #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_step_mult (
      .clock (clock),
      .reset (reset),
      .start (step_start_ff),
      .mag   (mag_ff),
      .gain  (gain),
      .done  (step_done),
      .step  (step)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_smoothed_out = rsp_out_ff;

   `AES_ASSERT_NEXT(a_accept_starts_mul, req_fire, state_ff == ST_MUL)
   `AES_ASSERT_IMP(a_out_within_limit, rsp_valid_ff, rsp_out_ff <= limit)
   `AES_ASSERT_IMP(a_out_matches_state, rsp_valid_ff, rsp_out_ff == smoothed_ff)
   `AES_ASSERT_NEXT(a_done_holds_on_stall, (state_ff == ST_DONE) && rsp_valid_ff && !rsp_ready,
                    state_ff == ST_DONE)

endmodule
